// ===== rtl/bslp_pkg.sv =====
// Package for the button short/long press detector.
// Holds the state encoding, event codes, register indexes and shared structs.
// No dependencies.
package bslp_pkg;

  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned EVENT_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd1;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd10;
  localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd1000;

  localparam logic [EVENT_W-1:0] EV_NONE  = 2'd0;
  localparam logic [EVENT_W-1:0] EV_SHORT = 2'd1;
  localparam logic [EVENT_W-1:0] EV_LONG  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE        = 3'd0,
    ST_DEB_PRESS   = 3'd1,
    ST_PRESSED     = 3'd2,
    ST_LONG        = 3'd3,
    ST_DEB_RELEASE = 3'd4
  } fsm_state_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] long_press_ticks;
  } cfg_t;

  // One sample handed from the input register to the state machine.
  typedef struct packed {
    logic go;
    logic raw_level;
  } step_t;

endpackage

// ===== rtl/bslp_if.sv =====
// Channel interfaces for the button short/long press detector.
// Depends on bslp_pkg for payload widths.
interface bslp_in_if;
  logic valid;
  logic ready;
  logic raw_level;
  modport source (output valid, output raw_level, input ready);
  modport sink   (input valid, input raw_level, output ready);
endinterface

interface bslp_out_if;
  logic                          valid;
  logic                          ready;
  logic [bslp_pkg::EVENT_W-1:0]  press_event;
  modport source (output valid, output press_event, input ready);
  modport sink   (input valid, input press_event, output ready);
endinterface

interface bslp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bslp_pkg::CFG_IDX_W-1:0]  index;
  logic [bslp_pkg::CFG_W-1:0]      data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/button_short_long_press_detector.sv =====
// Button short/long press detector: one result per accepted sample.
// A sample accepted goes into the input register, and its result then goes into the result register.
// Throughput: one sample per cycle while the result channel does not stall.
// Input register and result register decouple the two channels' stalls.
// Reset (rst_n low, synchronous): state idle, timers zero, limits 10 and 1000.
module button_short_long_press_detector #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  bslp_in_if.sink     in_ch,
  bslp_out_if.source  out_ch,
  bslp_cfg_if.sink    cfg_ch
);
  import bslp_pkg::*;

  cfg_t               cfg;
  step_t              step;
  logic               s1_valid_r;
  logic               s1_level_r;
  logic               out_valid_r;
  logic [EVENT_W-1:0] out_event_r;
  logic [EVENT_W-1:0] fsm_event;
  logic               s1_adv;
  logic               in_acc;

  bslp_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // The result register frees up when empty or when its transaction completes.
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign step.go        = s1_adv;
  assign step.raw_level = s1_level_r;

  bslp_fsm #(
    .TIMER_BITS (TIMER_BITS)
  ) u_fsm (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .cfg         (cfg),
    .press_event (fsm_event)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_level_r <= in_ch.raw_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_event_r <= fsm_event;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.press_event = out_event_r;

  a_reset_empties_pipe: assert property (@(posedge clk)
    !rst_n |=> (!s1_valid_r && !out_valid_r))
    else $error("pipeline not empty after reset");

  a_stalled_sample_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_level_r)))
    else $error("stalled input sample lost");

  a_no_step_into_full_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && out_valid_r) |-> out_ch.ready)
    else $error("result overwritten before its transaction");

endmodule

// ===== rtl/bslp_cfg_regs.sv =====
// Configuration registers of the press detector: debounce and long-press limits.
// Depends on bslp_pkg and bslp_cfg_if.
module bslp_cfg_regs (
  input  logic             clk,
  input  logic             rst_n,
  bslp_cfg_if.sink         cfg_ch,
  output bslp_pkg::cfg_t   cfg
);
  import bslp_pkg::*;

  logic [CFG_W-1:0] debounce_r;
  logic [CFG_W-1:0] long_press_r;
  logic             wr;

  assign cfg_ch.ready = 1'b1;
  assign wr = cfg_ch.valid && cfg_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RESET;
      long_press_r <= LONG_PRESS_RESET;
    end else if (wr) begin
      // Writes to indexes outside the register list are dropped.
      if (cfg_ch.index == REG_DEBOUNCE) begin
        debounce_r <= cfg_ch.data;
      end
      if (cfg_ch.index == REG_LONG_PRESS) begin
        long_press_r <= cfg_ch.data;
      end
    end
  end

  assign cfg.debounce_ticks   = debounce_r;
  assign cfg.long_press_ticks = long_press_r;

endmodule

// ===== rtl/bslp_fsm.sv =====
// Press state machine with its saturating change and press timers.
// Depends on bslp_pkg. Produces the event for the sample stepped this cycle.
module bslp_fsm #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bslp_pkg::step_t               step,
  input  bslp_pkg::cfg_t                cfg,
  output logic [bslp_pkg::EVENT_W-1:0]  press_event
);
  import bslp_pkg::*;

  localparam int unsigned CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

  fsm_state_t              state_r, state_nxt;
  logic [TIMER_BITS-1:0]   change_timer_r, change_timer_nxt;
  logic [TIMER_BITS-1:0]   press_timer_r, press_timer_nxt;
  logic [TIMER_BITS-1:0]   ct_inc, pt_inc;
  logic [CMP_W-1:0]        ct_ext, pt_ext, deb_ext, long_ext;
  logic                    pressed;

  assign pressed = !step.raw_level;

  // Both timers stop at all ones instead of wrapping.
  assign ct_inc = (&change_timer_r) ? change_timer_r : change_timer_r + 1'b1;
  assign pt_inc = (&press_timer_r) ? press_timer_r : press_timer_r + 1'b1;

  assign ct_ext   = CMP_W'(ct_inc);
  assign pt_ext   = CMP_W'(pt_inc);
  assign deb_ext  = CMP_W'(cfg.debounce_ticks);
  assign long_ext = CMP_W'(cfg.long_press_ticks);

  always_comb begin
    state_nxt        = state_r;
    change_timer_nxt = ct_inc;
    press_timer_nxt  = pt_inc;
    press_event      = EV_NONE;
    unique case (state_r)
      ST_DEB_PRESS: begin
        if (!pressed) begin
          state_nxt        = ST_IDLE;
          change_timer_nxt = '0;
        end else if (ct_ext >= deb_ext) begin
          press_timer_nxt = '0;
          state_nxt       = ST_PRESSED;
        end
      end
      ST_PRESSED: begin
        if (!pressed) begin
          change_timer_nxt = '0;
          state_nxt        = ST_DEB_RELEASE;
        end else if (pt_ext > long_ext) begin
          state_nxt = ST_LONG;
        end
      end
      ST_LONG: begin
        if (!pressed) begin
          change_timer_nxt = '0;
          state_nxt        = ST_DEB_RELEASE;
        end
      end
      ST_DEB_RELEASE: begin
        if (!pressed) begin
          // Release is confirmed one tick later than a press.
          if (ct_ext > deb_ext) begin
            press_event = (pt_ext < long_ext) ? EV_SHORT : EV_LONG;
            state_nxt   = ST_IDLE;
          end
        end else begin
          state_nxt        = (pt_ext < long_ext) ? ST_PRESSED : ST_LONG;
          change_timer_nxt = '0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        if (pressed) begin
          state_nxt        = ST_DEB_PRESS;
          change_timer_nxt = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      change_timer_r <= '0;
      press_timer_r  <= '0;
    end else if (step.go) begin
      state_r        <= state_nxt;
      change_timer_r <= change_timer_nxt;
      press_timer_r  <= press_timer_nxt;
    end
  end

  a_event_only_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    (step.go && press_event != EV_NONE) |-> state_r == ST_DEB_RELEASE)
    else $error("press event outside release debounce");

  a_event_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step.go && press_event != EV_NONE) |=> state_r == ST_IDLE)
    else $error("press event did not return to idle");

  a_confirm_clears_press_timer: assert property (@(posedge clk) disable iff (!rst_n)
    (step.go && state_r == ST_DEB_PRESS && state_nxt == ST_PRESSED)
      |=> press_timer_r == '0)
    else $error("press timer not cleared on press confirm");

endmodule
